// ===== src/lpc_pkg.sv =====
package lpc_pkg;

    // Fixed payload geometry of the block.
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int MAX_LOOKAHEAD_DEF = 512;

    // Number of squaring steps in the logarithm; one fraction bit each.
    localparam int LOG_ITERS = 16;
    localparam int ITER_W    = $clog2(LOG_ITERS);

    localparam logic signed [15:0] DB_FLOOR_Q88    = -16'sd30720;
    localparam logic signed [20:0] DB_PER_LOG2_Q16 = 21'sd394566;
    localparam logic signed [15:0] LOG2_PER_DB_Q16 = 16'sd10885;
    localparam logic        [16:0] K_SHIFT_LIMIT   = 17'd47;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_LOOKAHEAD = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQR,
        ST_DB,
        ST_TGT,
        ST_SMOOTH,
        ST_EXPO,
        ST_MANT,
        ST_GAIN,
        ST_SCALE,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic sqr;
        logic db;
        logic tgt;
        logic smooth;
        logic expo;
        logic mant;
        logic gain;
        logic scale;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic frame_ready;
        logic out_free;
    } t_status;

    // 2^(k/16) in Q15 for k = 0 .. 16.
    function automatic logic [16:0] pow2_q15(input logic [4:0] k);
        logic [16:0] v;
        begin
            case (k)
                5'd0:    v = 17'd32768;
                5'd1:    v = 17'd34219;
                5'd2:    v = 17'd35734;
                5'd3:    v = 17'd37316;
                5'd4:    v = 17'd38968;
                5'd5:    v = 17'd40693;
                5'd6:    v = 17'd42495;
                5'd7:    v = 17'd44376;
                5'd8:    v = 17'd46341;
                5'd9:    v = 17'd48393;
                5'd10:   v = 17'd50535;
                5'd11:   v = 17'd52773;
                5'd12:   v = 17'd55109;
                5'd13:   v = 17'd57549;
                5'd14:   v = 17'd60097;
                5'd15:   v = 17'd62757;
                5'd16:   v = 17'd65536;
                default: v = 17'd65536;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/lpc_ram.sv =====
module lpc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/lpc_ctrl.sv =====
module lpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  lpc_pkg::t_status i_status,
    output logic             o_in_stall,
    output lpc_pkg::t_cmd    o_cmd
);
    lpc_pkg::t_state r_state, n_state;
    logic [lpc_pkg::ITER_W-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpc_pkg::ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        case (r_state)
            lpc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lpc_pkg::ST_LOAD;
                end
            end
            lpc_pkg::ST_LOAD: begin
                n_iter  = '0;
                n_state = i_status.frame_ready ? lpc_pkg::ST_SQR : lpc_pkg::ST_IDLE;
            end
            lpc_pkg::ST_SQR: begin
                n_iter = r_iter + 1'b1;
                if (r_iter == lpc_pkg::ITER_W'(lpc_pkg::LOG_ITERS - 1)) begin
                    n_state = lpc_pkg::ST_DB;
                end
            end
            lpc_pkg::ST_DB:     n_state = lpc_pkg::ST_TGT;
            lpc_pkg::ST_TGT:    n_state = lpc_pkg::ST_SMOOTH;
            lpc_pkg::ST_SMOOTH: n_state = lpc_pkg::ST_EXPO;
            lpc_pkg::ST_EXPO:   n_state = lpc_pkg::ST_MANT;
            lpc_pkg::ST_MANT:   n_state = lpc_pkg::ST_GAIN;
            lpc_pkg::ST_GAIN:   n_state = lpc_pkg::ST_SCALE;
            lpc_pkg::ST_SCALE:  n_state = lpc_pkg::ST_PUSH;
            lpc_pkg::ST_PUSH: begin
                if (i_status.out_free) begin
                    n_state = lpc_pkg::ST_IDLE;
                end
            end
            default: n_state = lpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lpc_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            lpc_pkg::ST_LOAD:   o_cmd.load   = 1'b1;
            lpc_pkg::ST_SQR:    o_cmd.sqr    = 1'b1;
            lpc_pkg::ST_DB:     o_cmd.db     = 1'b1;
            lpc_pkg::ST_TGT:    o_cmd.tgt    = 1'b1;
            lpc_pkg::ST_SMOOTH: o_cmd.smooth = 1'b1;
            lpc_pkg::ST_EXPO:   o_cmd.expo   = 1'b1;
            lpc_pkg::ST_MANT:   o_cmd.mant   = 1'b1;
            lpc_pkg::ST_GAIN:   o_cmd.gain   = 1'b1;
            lpc_pkg::ST_SCALE:  o_cmd.scale  = 1'b1;
            lpc_pkg::ST_PUSH:   o_cmd.push   = i_status.out_free;
            default:            o_cmd        = '0;
        endcase
    end
endmodule

// ===== src/lpc_dp.sv =====
module lpc_dp #(
    parameter int MAX_LOOKAHEAD = lpc_pkg::MAX_LOOKAHEAD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpc_pkg::t_cmd                     i_cmd,
    output lpc_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic signed [lpc_pkg::SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic signed [lpc_pkg::SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic                              i_flush,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [lpc_pkg::SAMPLE_BITS-1:0] o_out_ch0,
    output logic signed [lpc_pkg::SAMPLE_BITS-1:0] o_out_ch1,
    output logic signed [15:0]                o_gain_db
);
    localparam int CH = lpc_pkg::CHANNELS;
    localparam int SB = lpc_pkg::SAMPLE_BITS;
    localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int LW = $clog2(MAX_LOOKAHEAD + 1);
    localparam int FW = CH * SB;

    // Configuration registers.
    logic signed [15:0] r_threshold;
    logic [15:0]        r_slope, r_attack, r_release;
    logic [9:0]         r_look_cfg;

    // Delay line bookkeeping.
    logic [AW-1:0] r_wp;
    logic [LW-1:0] r_fill;
    logic          r_ready, r_bypass;

    lpc_pkg::t_sample r_frame   [CH];
    lpc_pkg::t_sample r_delayed [CH];
    lpc_pkg::t_sample r_y       [CH];
    lpc_pkg::t_sample r_out     [CH];
    lpc_pkg::t_sample frame_in  [CH];

    logic [SB-1:0]      r_peak;
    logic [30:0]        r_m;
    logic [15:0]        r_frac;
    logic [3:0]         r_msb;
    logic               r_zero;
    logic signed [15:0] r_pk;
    logic signed [16:0] r_target;
    logic signed [31:0] r_gain;
    logic [16:0]        r_k;
    logic [15:0]        r_f;
    logic [16:0]        r_mant;
    logic [31:0]        r_gl;
    logic signed [15:0] r_gdb;
    logic               r_ovalid;

    logic [LW-1:0]  look, look_mod;
    logic [AW-1:0]  rd_addr;
    logic [FW-1:0]  wr_word, rd_word;
    logic [SB-1:0]  peak_in;

    assign frame_in[0] = i_flush ? '0 : i_sample_ch0;
    assign frame_in[1] = i_flush ? '0 : i_sample_ch1;

    always_comb begin
        if (32'(r_look_cfg) > 32'(MAX_LOOKAHEAD)) begin
            look = LW'(MAX_LOOKAHEAD);
        end else begin
            look = LW'(r_look_cfg);
        end
        look_mod = (look == LW'(MAX_LOOKAHEAD)) ? '0 : look;
    end

    always_comb begin
        int rd_i;
        rd_i = int'(r_wp) - int'(look_mod);
        if (rd_i < 0) begin
            rd_i = rd_i + MAX_LOOKAHEAD;
        end
        rd_addr = AW'(rd_i);
    end

    always_comb begin
        logic [SB-1:0] a;
        peak_in = '0;
        for (int c = 0; c < CH; c++) begin
            a = frame_in[c][SB-1] ? SB'(-frame_in[c]) : SB'(frame_in[c]);
            if (a > peak_in) begin
                peak_in = a;
            end
        end
        for (int c = 0; c < CH; c++) begin
            wr_word[c*SB +: SB] = frame_in[c];
        end
    end

    lpc_ram #(.WIDTH(FW), .DEPTH(MAX_LOOKAHEAD), .ADDR_W(AW)) u_delay (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_wp),
        .i_wdata (wr_word),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    // Normalisation for the logarithm.
    logic [3:0]  msb_c;
    logic [30:0] m_norm;
    always_comb begin
        msb_c = '0;
        for (int b = 0; b < SB; b++) begin
            if (r_peak[b]) begin
                msb_c = 4'(b);
            end
        end
        m_norm = 31'(r_peak) << (5'd30 - {1'b0, msb_c});
    end

    logic [61:0] sq;
    assign sq = 62'(r_m) * 62'(r_m);

    logic signed [20:0] l2;
    logic signed [41:0] db_p;
    logic signed [41:0] db_r;
    logic signed [15:0] db_c;
    always_comb begin
        l2   = {5'({1'b0, r_msb}) - 5'd15, r_frac};
        db_p = 42'(l2) * 42'(lpc_pkg::DB_PER_LOG2_Q16);
        db_r = db_p + 42'sd8388608;
        if (r_zero || ($signed(db_r[41:24]) < 18'(lpc_pkg::DB_FLOOR_Q88))) begin
            db_c = lpc_pkg::DB_FLOOR_Q88;
        end else begin
            db_c = db_r[39:24];
        end
    end

    logic signed [16:0] over;
    logic signed [33:0] tg_p;
    logic signed [16:0] tg_c;
    always_comb begin
        over = 17'(r_pk) - 17'(r_threshold);
        tg_p = 34'(over) * 34'($signed({1'b0, r_slope})) + 34'sd32768;
        tg_c = (over > 17'sd0) ? -tg_p[32:16] : '0;
    end

    logic signed [31:0] t16;
    logic [15:0]        alpha;
    logic signed [32:0] diff;
    logic signed [49:0] sm_p;
    always_comb begin
        t16   = 32'(r_target) <<< 8;
        alpha = (t16 < r_gain) ? r_attack : r_release;
        diff  = 33'(t16) - 33'(r_gain);
        sm_p  = 50'(diff) * 50'($signed({1'b0, alpha})) + 50'sd32768;
    end

    logic signed [47:0] ex_p;
    logic signed [31:0] e_c;
    logic [32:0]        ue_sum;
    always_comb begin
        ex_p = 48'(r_gain) * 48'(lpc_pkg::LOG2_PER_DB_Q16) + 48'sd32768;
        e_c  = ($signed(ex_p[47:16]) > 32'sd0) ? '0 : $signed(ex_p[47:16]);
        ue_sum = 33'(-e_c) + 33'd65535;
    end

    logic [16:0] tab_a, tab_b;
    logic [28:0] mt_p;
    logic [17:0] mant_c;
    always_comb begin
        tab_a  = lpc_pkg::pow2_q15({1'b0, r_f[15:12]});
        tab_b  = lpc_pkg::pow2_q15(5'({1'b0, r_f[15:12]} + 5'd1));
        mt_p   = 29'(tab_b - tab_a) * 29'(r_f[11:0]) + 29'd2048;
        mant_c = 18'(tab_a) + 18'(mt_p[28:12]);
    end

    logic [48:0] gs_v;
    logic [31:0] gl_c;
    always_comb begin
        gs_v = '0;
        if (r_k == '0) begin
            gl_c = 32'({r_mant, 16'b0});
        end else if (r_k > lpc_pkg::K_SHIFT_LIMIT) begin
            gl_c = '0;
        end else begin
            gs_v = (49'({r_mant, 16'b0}) + (49'd1 << (r_k[5:0] - 6'd1))) >> r_k[5:0];
            gl_c = gs_v[31:0];
        end
    end

    lpc_pkg::t_sample y_c [CH];
    always_comb begin
        logic signed [48:0] p;
        logic signed [17:0] y;
        for (int c = 0; c < CH; c++) begin
            p = 49'(r_delayed[c]) * 49'($signed({1'b0, r_gl})) + 49'sd1073741824;
            y = p[48:31];
            if (y > 18'sd32767) begin
                y_c[c] = 16'sd32767;
            end else if (y < -18'sd32768) begin
                y_c[c] = -16'sd32768;
            end else begin
                y_c[c] = y[15:0];
            end
        end
    end

    logic signed [32:0] gdb_s;
    assign gdb_s = 33'(r_gain) + 33'sd128;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= -16'sd5120;
            r_slope     <= 16'd49152;
            r_attack    <= 16'd136;
            r_release   <= 16'd14;
            r_look_cfg  <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_gain      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (lpc_pkg::t_cfg_idx'(i_cfg_index))
                    lpc_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    lpc_pkg::CFG_SLOPE:     r_slope     <= i_cfg_data;
                    lpc_pkg::CFG_ATTACK:    r_attack    <= i_cfg_data;
                    lpc_pkg::CFG_RELEASE:   r_release   <= i_cfg_data;
                    lpc_pkg::CFG_LOOKAHEAD: r_look_cfg  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_wp <= (r_wp == AW'(MAX_LOOKAHEAD - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill < LW'(MAX_LOOKAHEAD)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.smooth) begin
                r_gain <= r_gain + sm_p[47:16];
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_frame  <= frame_in;
            r_peak   <= peak_in;
            r_ready  <= (r_fill >= look);
            r_bypass <= (look == '0);
        end
        if (i_cmd.load) begin
            for (int c = 0; c < CH; c++) begin
                r_delayed[c] <= r_bypass ? r_frame[c] : rd_word[c*SB +: SB];
            end
            r_msb  <= msb_c;
            r_m    <= m_norm;
            r_frac <= '0;
            r_zero <= (r_peak == '0);
        end
        if (i_cmd.sqr) begin
            if (sq[61]) begin
                r_m    <= sq[61:31];
                r_frac <= {r_frac[14:0], 1'b1};
            end else begin
                r_m    <= sq[60:30];
                r_frac <= {r_frac[14:0], 1'b0};
            end
        end
        if (i_cmd.db) begin
            r_pk <= db_c;
        end
        if (i_cmd.tgt) begin
            r_target <= tg_c;
        end
        if (i_cmd.expo) begin
            r_k <= ue_sum[32:16];
            r_f <= e_c[15:0];
        end
        if (i_cmd.mant) begin
            r_mant <= mant_c[16:0];
        end
        if (i_cmd.gain) begin
            r_gl <= gl_c;
        end
        if (i_cmd.scale) begin
            r_y <= y_c;
        end
        if (i_cmd.push) begin
            r_out <= r_y;
            r_gdb <= gdb_s[23:8];
        end
    end

    assign o_status.frame_ready = r_ready;
    assign o_status.out_free    = !r_ovalid || !i_out_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_ch0   = r_out[0];
    assign o_out_ch1   = r_out[1];
    assign o_gain_db   = r_gdb;
endmodule

// ===== src/lookahead_peak_compressor.sv =====
// Feed-forward peak compressor with lookahead for a two-channel Q15 stream.
// Each input item is one frame; its channel peak drives a dB-domain detector
// (logarithm by repeated squaring, silence floored at -120 dB), a gain
// computer above the threshold, attack/release smoothing and a table-based
// conversion back to a linear gain, which scales the frame that entered
// lookahead_samples items earlier. Until that many frames have been written
// since reset an item only fills the delay line and gives no result; a flush
// item pushes a silent frame. One item is worked on at a time: a frame that
// gives a result passes the load state, the squaring loop of the logarithm
// on its single multiplier, the dB, target, smoothing, exponent, mantissa,
// gain and scale states and the push state into the output register, while
// a filling frame passes only the load state. The output register lets the
// next item be accepted while a result still waits to be taken. The
// configuration port never stalls and should be written only while idle.
module lookahead_peak_compressor #(
    parameter int MAX_LOOKAHEAD = lpc_pkg::MAX_LOOKAHEAD_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [lpc_pkg::SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic signed [lpc_pkg::SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic                                   i_flush,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [lpc_pkg::SAMPLE_BITS-1:0] o_out_ch0,
    output logic signed [lpc_pkg::SAMPLE_BITS-1:0] o_out_ch1,
    output logic signed [15:0]                     o_gain_db,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    lpc_pkg::t_cmd    cmd;
    lpc_pkg::t_status status;

    // Registers are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // The controller sequences one item through the arithmetic steps.
    lpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the registers, the delay line and the arithmetic.
    lpc_dp #(.MAX_LOOKAHEAD(MAX_LOOKAHEAD)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_ch0 (i_sample_ch0),
        .i_sample_ch1 (i_sample_ch1),
        .i_flush      (i_flush),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_ch0    (o_out_ch0),
        .o_out_ch1    (o_out_ch1),
        .o_gain_db    (o_gain_db)
    );
endmodule
